FILE: hw/rtl/csvf_pkg.sv
`default_nettype none

package csvf_pkg;

    // fixed field widths
    localparam int COEF_W    = 32;
    localparam int STATE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;
    localparam int PASS_W    = 4;
    localparam int PROD_W    = 64;
    localparam int RND_W     = 40;
    localparam int WIDE_W    = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_G      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_K      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 3'd5;

    // response modes
    localparam logic [MODE_W-1:0] MODE_LOWPASS    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BANDPASS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BANDREJECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEAK       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALLPASS    = 3'd5;

    // reset values
    localparam logic signed [COEF_W-1:0] COEF_G_RST  = 32'sd0;
    localparam logic signed [COEF_W-1:0] COEF_A1_RST = 32'sd16777216;
    localparam logic signed [COEF_W-1:0] COEF_A2_RST = 32'sd0;
    localparam logic signed [COEF_W-1:0] COEF_K_RST  = 32'sd33554432;
    localparam logic [MODE_W-1:0]        MODE_RST    = MODE_LOWPASS;
    localparam logic [PASS_W-1:0]        PASS_RST    = 4'd1;

    // coefficient and mode set shared by all sections
    typedef struct packed {
        logic signed [COEF_W-1:0] g;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] k;
        logic [MODE_W-1:0]        mode;
        logic [PASS_W-1:0]        pass_count;
    } t_cfg;

    // q8.24 product back to sample scale, round half up
    function automatic logic signed [RND_W-1:0] rnd_q24(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 64'sd8388608;
        return s[PROD_W-1:24];
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7fffffff);
        lo = WIDE_W'(32'sh80000000);
        if (x > hi) begin
            return hi[STATE_W-1:0];
        end else if (x < lo) begin
            return lo[STATE_W-1:0];
        end
        return x[STATE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csvf_in_if.sv
`default_nettype none

interface csvf_in_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvf_out_if.sv
`default_nettype none

interface csvf_out_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvf_cfg_if.sv
`default_nettype none

interface csvf_cfg_if;
    import csvf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvf_ram.sv
`default_nettype none

module csvf_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/csvf_cfg_regs.sv
`default_nettype none

module csvf_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_valid,
    input  wire logic [csvf_pkg::CFG_IDX_W-1:0]      i_wr_index,
    input  wire logic [csvf_pkg::COEF_W-1:0]         i_wr_data,
    output csvf_pkg::t_cfg                           o_cfg
);
    import csvf_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.g          <= COEF_G_RST;
            r_cfg.a1         <= COEF_A1_RST;
            r_cfg.a2         <= COEF_A2_RST;
            r_cfg.k          <= COEF_K_RST;
            r_cfg.mode       <= MODE_RST;
            r_cfg.pass_count <= PASS_RST;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                REG_COEF_G:      r_cfg.g          <= i_wr_data;
                REG_COEF_A1:     r_cfg.a1         <= i_wr_data;
                REG_COEF_A2:     r_cfg.a2         <= i_wr_data;
                REG_COEF_K:      r_cfg.k          <= i_wr_data;
                REG_FILTER_MODE: r_cfg.mode       <= i_wr_data[MODE_W-1:0];
                REG_PASS_COUNT:  r_cfg.pass_count <= i_wr_data[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hw/rtl/csvf_engine.sv
`default_nettype none

module csvf_engine #(
    parameter int MAX_PASSES  = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire csvf_pkg::t_cfg                i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  wire logic                          i_res_free,
    output logic                               o_res_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_res_sample
);
    import csvf_pkg::*;

    localparam int IDX_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
    localparam int CMP_W = (IDX_W + 1 > PASS_W) ? IDX_W + 1 : PASS_W;
    localparam int ENT_W = 2 * STATE_W;
    localparam logic signed [WIDE_W-1:0] Y_MAX =
        WIDE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] Y_MIN =
        WIDE_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_READ = 10'b00_0000_0010,
        S_LOAD = 10'b00_0000_0100,
        S_MUL1 = 10'b00_0000_1000,
        S_MUL2 = 10'b00_0001_0000,
        S_V1   = 10'b00_0010_0000,
        S_MUL3 = 10'b00_0100_0000,
        S_V2   = 10'b00_1000_0000,
        S_KV   = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [IDX_W-1:0]              r_idx;
    logic [MAX_PASSES-1:0]         r_valid;
    logic                          r_rd_valid;
    logic signed [SAMPLE_BITS-1:0] r_v0;
    logic signed [STATE_W-1:0]     r_s1, r_s2, r_d, r_v1, r_v2;
    logic signed [RND_W-1:0]       r_acc, r_kv;
    logic signed [PROD_W-1:0]      r_prod;

    logic [ENT_W-1:0]              ram_q;
    logic                          ram_we;
    logic [ENT_W-1:0]              ram_wdata;
    logic signed [STATE_W-1:0]     s1_c, s2_c, s1_new, s2_new;
    logic signed [COEF_W-1:0]      mul_a;
    logic signed [STATE_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod_c;
    logic                          mul_en;
    logic signed [WIDE_W-1:0]      v0_w, kv_w, v2_w, y_w;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          last_pass;

    // integrator pair per section: {s1, s2}
    csvf_ram #(
        .W     (ENT_W),
        .DEPTH (MAX_PASSES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

    // entries never written read as zero
    assign s1_c = r_rd_valid ? $signed(ram_q[ENT_W-1:STATE_W]) : '0;
    assign s2_c = r_rd_valid ? $signed(ram_q[STATE_W-1:0]) : '0;

    // integrator update, written back once v1 and v2 are known
    assign s1_new    = sat32((WIDE_W'(r_v1) <<< 1) - WIDE_W'(r_s1));
    assign s2_new    = sat32((WIDE_W'(r_v2) <<< 1) - WIDE_W'(r_s2));
    assign ram_we    = (r_state == S_KV);
    assign ram_wdata = {s1_new, s2_new};

    // shared multiplier operand select
    always_comb begin
        mul_a  = i_cfg.a1;
        mul_b  = r_s1;
        mul_en = 1'b0;
        unique case (r_state)
            S_MUL1: begin
                mul_a  = i_cfg.a1;
                mul_b  = r_s1;
                mul_en = 1'b1;
            end
            S_MUL2: begin
                mul_a  = i_cfg.a2;
                mul_b  = r_d;
                mul_en = 1'b1;
            end
            S_MUL3: begin
                mul_a  = i_cfg.g;
                mul_b  = r_v1;
                mul_en = 1'b1;
            end
            S_V2: begin
                mul_a  = i_cfg.k;
                mul_b  = r_v1;
                mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // section response by mode
    assign v0_w = WIDE_W'(r_v0);
    assign kv_w = WIDE_W'(r_kv);
    assign v2_w = WIDE_W'(r_v2);

    always_comb begin
        unique case (i_cfg.mode)
            MODE_LOWPASS:    y_w = v2_w;
            MODE_HIGHPASS:   y_w = v0_w - kv_w - v2_w;
            MODE_BANDPASS:   y_w = WIDE_W'(r_v1);
            MODE_BANDREJECT: y_w = v0_w - kv_w;
            MODE_PEAK:       y_w = (v2_w <<< 1) - v0_w + kv_w;
            MODE_ALLPASS:    y_w = v0_w - (kv_w <<< 1);
            default:         y_w = v0_w;
        endcase
    end

    always_comb begin
        if (y_w > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (y_w < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_w[SAMPLE_BITS-1:0];
        end
    end

    // zero pass count runs one section, large counts stop at the last entry
    assign last_pass = (CMP_W'(r_idx) + CMP_W'(1) >= CMP_W'(i_cfg.pass_count)) ||
                       (r_idx == IDX_W'(MAX_PASSES - 1));

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_OUT) && last_pass && i_res_free;
    assign o_res_sample = y_sat;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_V1;
            S_V1:   n_state = S_MUL3;
            S_MUL3: n_state = S_V2;
            S_V2:   n_state = S_KV;
            S_KV:   n_state = S_OUT;
            S_OUT: begin
                if (!last_pass) begin
                    n_state = S_READ;
                end else if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if ((r_state == S_OUT) && !last_pass) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (ram_we) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_v0 <= i_in_sample;
        end
        if (r_state == S_READ) begin
            r_rd_valid <= r_valid[r_idx];
        end
        if (r_state == S_LOAD) begin
            r_s1 <= s1_c;
            r_s2 <= s2_c;
            r_d  <= sat32(WIDE_W'(r_v0) - WIDE_W'(s2_c));
        end
        if (mul_en) begin
            r_prod <= prod_c;
        end
        if (r_state == S_MUL2) begin
            r_acc <= rnd_q24(r_prod);
        end
        if (r_state == S_V1) begin
            r_v1 <= sat32(WIDE_W'(r_acc) + WIDE_W'(rnd_q24(r_prod)));
        end
        if (r_state == S_V2) begin
            r_v2 <= sat32(WIDE_W'(r_s2) + WIDE_W'(rnd_q24(r_prod)));
        end
        if (r_state == S_KV) begin
            r_kv <= rnd_q24(r_prod);
        end
        if ((r_state == S_OUT) && !last_pass) begin
            r_v0 <= y_sat;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cascaded_state_variable_filter_core.sv
// Cascaded state-variable filter core.
// i_sample: input words, one signed audio sample each (valid/ready).
// o_sample: output words, one filtered sample per input word (valid/ready).
// i_cfg: register writes (index, data); always ready, write only while idle.
// Each word runs through 1 to MAX_PASSES sections in series. Per section the
// sequencer reads the integrator pair from RAM, runs four products through
// one shared 32x32 multiplier and writes the pair back.
// An input word is taken in the idle cycle; its result is written to the output
// register when its last section ends and is valid on o_sample from then on.
// Words are taken only while the sequencer is idle, so a new word is never
// accepted before the last section of the previous word has finished.
// The next input word is accepted as soon as the result sits in the output
// register. If the receiver stalls with the output register full, the last
// section holds its result and no new word is accepted until it moves.
// Reset clears all coefficients to their defaults and marks every integrator
// pair as zero through per-section valid flags; no clearing pass is needed.
`default_nettype none

module cascaded_state_variable_filter_core #(
    parameter int MAX_PASSES  = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    csvf_in_if.sink     i_sample,
    csvf_out_if.source  o_sample,
    csvf_cfg_if.sink    i_cfg
);
    import csvf_pkg::*;

    t_cfg                          cfg;
    logic                          res_valid;
    logic                          res_free;
    logic signed [SAMPLE_BITS-1:0] res_sample;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    assign i_cfg.ready = 1'b1;
    assign in_sample   = i_sample.sample_in;

    // configuration registers
    csvf_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // section sequencer with integrator memory
    csvf_engine #(
        .MAX_PASSES  (MAX_PASSES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_sample.valid),
        .o_in_ready   (i_sample.ready),
        .i_in_sample  (in_sample),
        .i_res_free   (res_free),
        .o_res_valid  (res_valid),
        .o_res_sample (res_sample)
    );

    // output register, free when empty or draining this cycle
    assign res_free = !r_out_valid || o_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_sample.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_sample <= res_sample;
        end
    end

    assign o_sample.valid      = r_out_valid;
    assign o_sample.sample_out = r_out_sample;

endmodule

`default_nettype wire

FILE: tb/svf_response_checker.sv
module svf_response_checker #(
    parameter int MAX_PASSES  = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_valid,
    input  logic                                 i_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_data,
    input  logic                                 i_result_valid,
    input  logic                                 i_result_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_result_data,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [csvf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [csvf_pkg::COEF_W-1:0]          i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import csvf_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // shadow copy of the coefficient set and the section integrators
    logic signed [COEF_W-1:0]  coef_g;
    logic signed [COEF_W-1:0]  coef_a1;
    logic signed [COEF_W-1:0]  coef_a2;
    logic signed [COEF_W-1:0]  coef_k;
    logic [MODE_W-1:0]         resp_mode;
    logic [PASS_W-1:0]         stage_count;
    logic signed [STATE_W-1:0] integ_one [MAX_PASSES];
    logic signed [STATE_W-1:0] integ_two [MAX_PASSES];

    t_sample expected_samples[$];
    int      result_num;

    // clamp to a signed range of the given width
    function automatic longint clamp_to(input longint x, input int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (x > hi) begin
            return hi;
        end
        if (x < -hi - 1) begin
            return -hi - 1;
        end
        return x;
    endfunction

    // q8.24 coefficient times sample-scaled value, round half up
    function automatic longint scale_q24(input longint c, input longint v);
        return (c * v + 64'sd8388608) >>> 24;
    endfunction

    // one trapezoidal section, updates its integrator pair
    function automatic longint run_stage(input int idx, input longint v0);
        longint s1;
        longint s2;
        longint d;
        longint v1;
        longint v2;
        longint kv;
        longint y;
        s1 = integ_one[idx];
        s2 = integ_two[idx];
        d  = clamp_to(v0 - s2, STATE_W);
        v1 = clamp_to(scale_q24(coef_a1, s1) + scale_q24(coef_a2, d), STATE_W);
        v2 = clamp_to(s2 + scale_q24(coef_g, v1), STATE_W);
        kv = scale_q24(coef_k, v1);
        integ_one[idx] = STATE_W'(clamp_to(2 * v1 - s1, STATE_W));
        integ_two[idx] = STATE_W'(clamp_to(2 * v2 - s2, STATE_W));
        case (resp_mode)
            MODE_LOWPASS:    y = v2;
            MODE_HIGHPASS:   y = v0 - kv - v2;
            MODE_BANDPASS:   y = v1;
            MODE_BANDREJECT: y = v0 - kv;
            MODE_PEAK:       y = 2 * v2 - v0 + kv;
            MODE_ALLPASS:    y = v0 - 2 * kv;
            default:         y = v0;
        endcase
        return clamp_to(y, SAMPLE_BITS);
    endfunction

    // whole cascade for one input word
    function automatic t_sample filter_sample(input t_sample x_in);
        int     passes;
        int     i;
        longint x;
        passes = stage_count;
        if (passes == 0) begin
            passes = 1;
        end
        if (passes > MAX_PASSES) begin
            passes = MAX_PASSES;
        end
        x = x_in;
        for (i = 0; i < passes; i++) begin
            x = run_stage(i, x);
        end
        return t_sample'(x);
    endfunction

    // watch the three channels, predict and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_g      <= COEF_G_RST;
            coef_a1     <= COEF_A1_RST;
            coef_a2     <= COEF_A2_RST;
            coef_k      <= COEF_K_RST;
            resp_mode   <= MODE_RST;
            stage_count <= PASS_RST;
            for (int i = 0; i < MAX_PASSES; i++) begin
                integ_one[i] = '0;
                integ_two[i] = '0;
            end
            expected_samples.delete();
            result_num    <= 0;
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            // register writes, only seen while the block is idle
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_G:      coef_g      <= i_cfg_data;
                    REG_COEF_A1:     coef_a1     <= i_cfg_data;
                    REG_COEF_A2:     coef_a2     <= i_cfg_data;
                    REG_COEF_K:      coef_k      <= i_cfg_data;
                    REG_FILTER_MODE: resp_mode   <= i_cfg_data[MODE_W-1:0];
                    REG_PASS_COUNT:  stage_count <= i_cfg_data[PASS_W-1:0];
                    default: ;
                endcase
            end

            // output word against the oldest prediction
            if (i_result_valid && i_result_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected output word %0d (value %0d)",
                             $time, result_num, i_result_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    t_sample want;
                    want = expected_samples.pop_front();
                    if (want !== i_result_data) begin
                        $display("%0t: sample_out mismatch on word %0d, expected %0d actual %0d",
                                 $time, result_num, want, i_result_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
                result_num <= result_num + 1;
            end

            // input word accepted, run the predictor
            if (i_sample_valid && i_sample_ready) begin
                expected_samples.push_back(filter_sample(i_sample_data));
            end

            o_outstanding <= expected_samples.size();
        end
    end

endmodule

FILE: tb/tb_cascaded_state_variable_filter_core.sv
module tb_cascaded_state_variable_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import csvf_pkg::*;

    localparam int MAX_PASSES     = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int ITEM_TARGET    = 1050;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 3000;

    // register indexes with nothing behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // mode codes with no response of their own
    localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_POS_RAIL = 32'sh7fffffff;
    localparam logic signed [COEF_W-1:0] COEF_NEG_RAIL = 32'sh80000000;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {WAVE_FULL, WAVE_QUIET, WAVE_RAIL, WAVE_NEAR_RAIL} t_wave;
    typedef enum int {RX_OPEN, RX_MOSTLY, RX_PATTERN, RX_COIN, RX_SPARSE} t_rx_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic hold_off_req = 1'b0;
    int   burst_left   = 0;
    int   sent_total   = 0;
    int   fail_count;
    int   outstanding;
    int   dir_passes [8] = '{1, 2, 8, 3, 0, 9, 15, 4};

    csvf_in_if  #(.W(SAMPLE_BITS)) sample_if ();
    csvf_out_if #(.W(SAMPLE_BITS)) result_if ();
    csvf_cfg_if                    cfg_if ();

    cascaded_state_variable_filter_core #(
        .MAX_PASSES  (MAX_PASSES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_sample (result_if),
        .i_cfg    (cfg_if)
    );

    svf_response_checker #(
        .MAX_PASSES  (MAX_PASSES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (sample_if.valid),
        .i_sample_ready (sample_if.ready),
        .i_sample_data  (sample_if.sample_in),
        .i_result_valid (result_if.valid),
        .i_result_ready (result_if.ready),
        .i_result_data  (result_if.sample_out),
        .i_cfg_valid    (cfg_if.valid),
        .i_cfg_ready    (cfg_if.ready),
        .i_cfg_index    (cfg_if.index),
        .i_cfg_data     (cfg_if.data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // coefficients for a stable section from g and k
    function automatic t_cfg tuned_setting(input longint g, input longint k);
        t_cfg   c;
        longint den;
        c    = '0;
        den  = 64'sd16777216 + ((g * (g + k)) >>> 24);
        c.g  = COEF_W'(g);
        c.k  = COEF_W'(k);
        c.a1 = COEF_W'((64'sd1 <<< 48) / den);
        c.a2 = COEF_W'((g * longint'(c.a1)) >>> 24);
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_rail();
        case ($urandom_range(0, 5))
            0:       return COEF_POS_RAIL;
            1:       return COEF_NEG_RAIL;
            2:       return '0;
            3:       return -1;
            4:       return 32'sd16777216;
            default: return 32'sd1;
        endcase
    endfunction

    // mostly tuned filters, some rail and raw coefficient sets
    function automatic t_cfg random_setting();
        t_cfg   c;
        int     flavor;
        longint g;
        longint k;
        flavor = $urandom_range(0, 9);
        if (flavor < 7) begin
            g = longint'($urandom_range(1, 1 << $urandom_range(10, 25)));
            k = longint'($urandom_range(0, 1 << 25));
            c = tuned_setting(g, k);
        end else if (flavor < 9) begin
            c    = '0;
            c.g  = pick_rail();
            c.a1 = pick_rail();
            c.a2 = pick_rail();
            c.k  = pick_rail();
        end else begin
            c    = '0;
            c.g  = $urandom();
            c.a1 = $urandom();
            c.a2 = $urandom();
            c.k  = $urandom();
        end
        if ($urandom_range(0, 9) == 0) begin
            c.mode = $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
        end else begin
            c.mode = MODE_W'($urandom_range(MODE_LOWPASS, MODE_ALLPASS));
        end
        case ($urandom_range(0, 9))
            0:       c.pass_count = '0;
            1:       c.pass_count = PASS_W'($urandom_range(MAX_PASSES + 1, 15));
            default: c.pass_count = PASS_W'($urandom_range(1, MAX_PASSES));
        endcase
        return c;
    endfunction

    function automatic t_sample pick_sample(input t_wave wave);
        t_sample s;
        case (wave)
            WAVE_FULL:  s = t_sample'($urandom());
            WAVE_QUIET: s = t_sample'(int'($urandom_range(0, 8191)) - 4096);
            WAVE_RAIL:  s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            default: begin
                if ($urandom_range(0, 1)) begin
                    s = SAMPLE_MAX - t_sample'($urandom_range(0, 255));
                end else begin
                    s = SAMPLE_MIN + t_sample'($urandom_range(0, 255));
                end
            end
        endcase
        return s;
    endfunction

    // one register write, valid left high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    // full coefficient set, spare bits of mode and count sometimes set
    task automatic load_setting(input t_cfg c);
        logic [COEF_W-1:0] mode_word;
        logic [COEF_W-1:0] pass_word;
        mode_word = $urandom_range(0, 1) ? $urandom() : '0;
        pass_word = $urandom_range(0, 1) ? $urandom() : '0;
        mode_word[MODE_W-1:0] = c.mode;
        pass_word[PASS_W-1:0] = c.pass_count;
        write_reg(REG_COEF_G, c.g);
        write_reg(REG_COEF_A1, c.a1);
        write_reg(REG_COEF_A2, c.a2);
        write_reg(REG_COEF_K, c.k);
        write_reg(REG_FILTER_MODE, mode_word);
        write_reg(REG_PASS_COUNT, pass_word);
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom());
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one word and wait for it to be taken
    task automatic send_sample(input t_sample s);
        sample_if.valid     <= 1'b1;
        sample_if.sample_in <= s;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        sent_total++;
    endtask

    // words in bursts with random gaps between them
    task automatic run_phase(input int n_items, input t_wave wave, input int gap_max);
        int i;
        int gap;
        for (i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0) begin
                    sample_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            send_sample(pick_sample(wave));
            burst_left--;
        end
    endtask

    // wait for every prediction to be met, then let the pipeline empty
    task automatic settle();
        sample_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver: changing stall styles plus one long hold-off on request
    initial begin : receiver
        int        hold_left;
        int        style_left;
        int        tick;
        t_rx_style rx_style;
        hold_left  = 0;
        style_left = 0;
        tick       = 0;
        rx_style   = RX_OPEN;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                style_left = $urandom_range(50, 300);
                rx_style   = t_rx_style'($urandom_range(RX_OPEN, RX_SPARSE));
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_OPEN:    result_if.ready <= 1'b1;
                    RX_MOSTLY:  result_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: result_if.ready <= ((tick % 5) >= 2);
                    RX_COIN:    result_if.ready <= $urandom_range(0, 1);
                    default:    result_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("cascaded_state_variable_filter_core regression: fail");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_cfg c;
        int   m;
        int   phase;
        int   gap_max;
        sample_if.valid     = 1'b0;
        sample_if.sample_in = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        i_rst_n             = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients, sample extremes
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-1);
        send_sample(1);
        settle();

        // every mode incl. unused codes, zero and oversized pass counts
        c = tuned_setting(64'sd4194304, 64'sd16777216);
        for (m = MODE_LOWPASS; m <= MODE_UNUSED_B; m++) begin
            c.mode       = MODE_W'(m);
            c.pass_count = PASS_W'(dir_passes[m]);
            load_setting(c);
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MIN);
            settle();
        end

        // rail coefficients drive every intermediate into saturation
        c.g          = COEF_POS_RAIL;
        c.a1         = COEF_NEG_RAIL;
        c.a2         = COEF_POS_RAIL;
        c.k          = COEF_NEG_RAIL;
        c.mode       = MODE_PEAK;
        c.pass_count = PASS_W'(MAX_PASSES);
        write_reg(REG_UNUSED_A, $urandom());
        write_reg(REG_UNUSED_B, $urandom());
        load_setting(c);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        settle();

        // random settings and words, one long receiver hold-off early on
        phase = 0;
        while (sent_total < ITEM_TARGET) begin
            load_setting(random_setting());
            if (phase == 3) begin
                hold_off_req = 1'b1;
                run_phase(48, t_wave'($urandom_range(WAVE_FULL, WAVE_NEAR_RAIL)), 0);
            end else begin
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                run_phase($urandom_range(10, 40),
                          t_wave'($urandom_range(WAVE_FULL, WAVE_NEAR_RAIL)), gap_max);
            end
            settle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("cascaded_state_variable_filter_core regression: pass");
        end else begin
            $display("cascaded_state_variable_filter_core regression: fail");
        end
        $finish;
    end

endmodule
